// ----- hdl/pidpc_pkg.sv -----
// Shared types, register indexes and constants for the PID position controller.
package pidpc_pkg;

   localparam int DEF_POS_WIDTH = 32;
   localparam int DEF_SUM_WIDTH = 40;

   localparam int COEF_W   = 16;
   localparam int STEP_W   = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PROP       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_INTEGRAL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_DERIV     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POSITION_WINDOW = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_LEVEL    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_CAP        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDUP_ERROR    = 3'd6;

   localparam logic [15:0] RST_GAIN_PROP       = 16'd256;
   localparam logic [15:0] RST_RATIO_INTEGRAL  = 16'd16;
   localparam logic [15:0] RST_RATIO_DERIV     = 16'd0;
   localparam logic [9:0]  RST_POSITION_WINDOW = 10'd5;
   localparam logic [7:0]  RST_SETTLE_LEVEL    = 8'd55;
   localparam logic [7:0]  RST_DUTY_CAP        = 8'd200;
   localparam logic [15:0] RST_WINDUP_ERROR    = 16'd200;

   localparam logic [1:0] DIR_STOP    = 2'd0;
   localparam logic [1:0] DIR_FORWARD = 2'd1;
   localparam logic [1:0] DIR_REVERSE = 2'd2;

   localparam logic [7:0] DUTY_STOPPED = 8'd255;
   localparam logic [7:0] DRIVE_MAX    = 8'd255;

   localparam logic [STEP_W-1:0] STEP_LAST = 4'd15;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_I,
      ST_MUL_D,
      ST_SCALE,
      ST_MUL_K,
      ST_FINISH,
      ST_RESULT
   } state_type;

endpackage

// ----- hdl/pid_position_controller.sv -----
// An idle tick or a tick that ends the move goes from the check state straight to the result state.
// A full PID tick runs three 16-step passes of one shift-add unit before its result is shown.
// One transaction is in work at a time, so the next one is accepted only after the last has
// loaded its result for output, and later while the receiver holds off the result.
// A finished result waits in the output register while the next transaction is accepted.
// Synchronous active-high reset restores the register defaults and leaves the controller idle
// with goal, error history, integral and last drive cleared.
module pid_position_controller
   import pidpc_pkg::*;
#(
   parameter int POS_WIDTH = DEF_POS_WIDTH,
   parameter int SUM_WIDTH = DEF_SUM_WIDTH,
   localparam int REQ_DATA_W = ((2 * POS_WIDTH + 1 + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: target, position, emergency.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: op.
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Fields from bit 0: drive_dir, duty, control_value, done_res, emergency_stop.
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_data
);

   localparam int E_W = POS_WIDTH + 1;
   localparam int D_W = POS_WIDTH + 2;
   localparam int SW = ((SUM_WIDTH > E_W) ? SUM_WIDTH : E_W) + 1;
   localparam int P1 = SUM_WIDTH + COEF_W + 1;
   localparam int P2 = D_W + 4 + COEF_W + 1;
   localparam int PMAX = (P1 > P2) ? P1 : P2;
   localparam int ACC_W = ((PMAX > 48) ? PMAX : 48) + 2;
   localparam logic signed [ACC_W-1:0] INNER_LIM = ACC_W'(1 << 30);

   state_type state_ff, state_in;

   logic [15:0] gain_prop_ff, ratio_integral_ff, ratio_deriv_ff, windup_error_ff;
   logic [9:0]  position_window_ff;
   logic [7:0]  settle_level_ff, duty_cap_ff;

   logic signed [POS_WIDTH-1:0] goal_ff, goal_in;
   logic signed [E_W-1:0]       prev_err_ff, prev_err_in;
   logic signed [SUM_WIDTH-1:0] err_sum_ff, err_sum_in;
   logic signed [8:0]           last_drive_ff, last_drive_in;
   logic                        moving_ff, moving_in;

   logic signed [POS_WIDTH-1:0] pos_ff, pos_in;
   logic                        emer_ff, emer_in;
   logic [E_W-1:0]              aerr_ff, aerr_in;
   logic signed [D_W-1:0]       d_ff, d_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic signed [ACC_W-1:0]     oper_ff, oper_in;
   logic [COEF_W-1:0]           coef_ff, coef_in;
   logic [STEP_W-1:0]           cnt_ff, cnt_in;
   logic                        neg_ff, neg_in;

   logic [1:0]        pend_dir_ff, pend_dir_in;
   logic [7:0]        pend_duty_ff, pend_duty_in;
   logic signed [8:0] pend_cv_ff, pend_cv_in;
   logic              pend_done_ff, pend_done_in;
   logic              pend_emer_ff, pend_emer_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic signed [E_W-1:0]       err_w;
   logic [E_W-1:0]              aerr_w;
   logic                        finish_w;
   logic signed [SW-1:0]        sum_wide_w;
   logic signed [SUM_WIDTH-1:0] sum_sat_w;
   logic signed [D_W-1:0]       d_w;
   logic signed [ACC_W-1:0]     step_w;
   logic signed [ACC_W-1:0]     inner_w;
   logic signed [ACC_W-1:0]     mag_w;
   logic                        big_w;
   logic [7:0]                  m_w;
   logic signed [8:0]           cv_w;
   logic                        slot_free_w;
   logic                        req_acc_w;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc_w  = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign slot_free_w = !rsp_valid_ff || rsp_tready;

   assign err_w  = E_W'(goal_ff) - E_W'(pos_ff);
   assign aerr_w = err_w[E_W-1] ? E_W'(-err_w) : E_W'(err_w);
   assign finish_w = (aerr_w <= E_W'(position_window_ff))
                     && (last_drive_ff <= $signed({1'b0, settle_level_ff}));

   assign sum_wide_w = SW'(err_sum_ff) + SW'(err_w);
   always_comb begin
      if (sum_wide_w[SW-1:SUM_WIDTH-1] == {(SW-SUM_WIDTH+1){1'b0}}
          || sum_wide_w[SW-1:SUM_WIDTH-1] == {(SW-SUM_WIDTH+1){1'b1}}) begin
         sum_sat_w = sum_wide_w[SUM_WIDTH-1:0];
      end else if (sum_wide_w[SW-1]) begin
         sum_sat_w = {1'b1, {(SUM_WIDTH-1){1'b0}}};
      end else begin
         sum_sat_w = {1'b0, {(SUM_WIDTH-1){1'b1}}};
      end
   end

   assign d_w = D_W'(err_w) - D_W'(prev_err_ff);

   assign step_w = coef_ff[0] ? (acc_ff + oper_ff) : acc_ff;

   always_comb begin
      if (acc_ff > INNER_LIM) begin
         inner_w = INNER_LIM;
      end else if (acc_ff < -INNER_LIM) begin
         inner_w = -INNER_LIM;
      end else begin
         inner_w = acc_ff;
      end
   end
   assign mag_w = inner_w[ACC_W-1] ? -inner_w : inner_w;

   assign big_w = |acc_ff[ACC_W-1:28];
   assign m_w   = big_w ? DRIVE_MAX : acc_ff[27:20];
   assign cv_w  = neg_ff ? -$signed({1'b0, m_w}) : $signed({1'b0, m_w});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc_w) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (moving_ff && !finish_w && !emer_ff) begin
               state_in = ST_MUL_I;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_MUL_I: begin
            if (cnt_ff == STEP_LAST) begin
               state_in = ST_MUL_D;
            end
         end
         ST_MUL_D: begin
            if (cnt_ff == STEP_LAST) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_MUL_K;
         end
         ST_MUL_K: begin
            if (cnt_ff == STEP_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (slot_free_w) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      goal_in       = goal_ff;
      prev_err_in   = prev_err_ff;
      err_sum_in    = err_sum_ff;
      last_drive_in = last_drive_ff;
      moving_in     = moving_ff;
      pos_in        = pos_ff;
      emer_in       = emer_ff;
      aerr_in       = aerr_ff;
      d_in          = d_ff;
      acc_in        = acc_ff;
      oper_in       = oper_ff;
      coef_in       = coef_ff;
      cnt_in        = cnt_ff;
      neg_in        = neg_ff;
      pend_dir_in   = pend_dir_ff;
      pend_duty_in  = pend_duty_ff;
      pend_cv_in    = pend_cv_ff;
      pend_done_in  = pend_done_ff;
      pend_emer_in  = pend_emer_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc_w) begin
               pos_in  = req_tdata[2*POS_WIDTH-1:POS_WIDTH];
               emer_in = req_tdata[2*POS_WIDTH];
               if (req_tuser) begin
                  goal_in       = req_tdata[POS_WIDTH-1:0];
                  prev_err_in   = '0;
                  err_sum_in    = '0;
                  last_drive_in = '0;
                  moving_in     = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            pend_dir_in  = DIR_STOP;
            pend_duty_in = DUTY_STOPPED;
            pend_cv_in   = '0;
            pend_done_in = 1'b0;
            pend_emer_in = 1'b0;
            if (moving_ff && finish_w) begin
               moving_in    = 1'b0;
               pend_done_in = 1'b1;
            end else if (moving_ff && emer_ff) begin
               moving_in    = 1'b0;
               pend_done_in = 1'b1;
               pend_emer_in = 1'b1;
            end else if (moving_ff) begin
               err_sum_in  = sum_sat_w;
               prev_err_in = err_w;
               d_in        = d_w;
               aerr_in     = aerr_w;
               acc_in      = ACC_W'(err_w) <<< 12;
               oper_in     = ACC_W'(sum_sat_w);
               coef_in     = ratio_integral_ff;
               cnt_in      = '0;
            end
         end
         ST_MUL_I: begin
            acc_in  = step_w;
            oper_in = oper_ff <<< 1;
            coef_in = coef_ff >> 1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == STEP_LAST) begin
               oper_in = ACC_W'(d_ff) <<< 4;
               coef_in = ratio_deriv_ff;
            end
         end
         ST_MUL_D: begin
            acc_in  = step_w;
            oper_in = oper_ff <<< 1;
            coef_in = coef_ff >> 1;
            cnt_in  = cnt_ff + 1'b1;
         end
         ST_SCALE: begin
            neg_in  = inner_w[ACC_W-1];
            oper_in = {{(ACC_W-31){1'b0}}, mag_w[30:0]};
            coef_in = gain_prop_ff;
            acc_in  = '0;
            cnt_in  = '0;
         end
         ST_MUL_K: begin
            acc_in  = step_w;
            oper_in = oper_ff <<< 1;
            coef_in = coef_ff >> 1;
            cnt_in  = cnt_ff + 1'b1;
         end
         ST_FINISH: begin
            if (big_w && (aerr_ff > E_W'(windup_error_ff))) begin
               err_sum_in = '0;
            end
            last_drive_in = cv_w;
            pend_cv_in    = cv_w;
            pend_dir_in   = cv_w[8] ? DIR_REVERSE : DIR_FORWARD;
            pend_duty_in  = (m_w > duty_cap_ff) ? duty_cap_ff : m_w;
            pend_done_in  = 1'b0;
            pend_emer_in  = 1'b0;
         end
         ST_RESULT: begin
            if (slot_free_w) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, pend_emer_ff, pend_done_ff, pend_cv_ff,
                               pend_duty_ff, pend_dir_ff};
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_tready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         goal_ff            <= '0;
         prev_err_ff        <= '0;
         err_sum_ff         <= '0;
         last_drive_ff      <= '0;
         moving_ff          <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         gain_prop_ff       <= RST_GAIN_PROP;
         ratio_integral_ff  <= RST_RATIO_INTEGRAL;
         ratio_deriv_ff     <= RST_RATIO_DERIV;
         position_window_ff <= RST_POSITION_WINDOW;
         settle_level_ff    <= RST_SETTLE_LEVEL;
         duty_cap_ff        <= RST_DUTY_CAP;
         windup_error_ff    <= RST_WINDUP_ERROR;
      end else begin
         state_ff      <= state_in;
         goal_ff       <= goal_in;
         prev_err_ff   <= prev_err_in;
         err_sum_ff    <= err_sum_in;
         last_drive_ff <= last_drive_in;
         moving_ff     <= moving_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_GAIN_PROP:       gain_prop_ff       <= csr_data;
               CSR_RATIO_INTEGRAL:  ratio_integral_ff  <= csr_data;
               CSR_RATIO_DERIV:     ratio_deriv_ff     <= csr_data;
               CSR_POSITION_WINDOW: position_window_ff <= csr_data[9:0];
               CSR_SETTLE_LEVEL:    settle_level_ff    <= csr_data[7:0];
               CSR_DUTY_CAP:        duty_cap_ff        <= csr_data[7:0];
               CSR_WINDUP_ERROR:    windup_error_ff    <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      emer_ff      <= emer_in;
      aerr_ff      <= aerr_in;
      d_ff         <= d_in;
      acc_ff       <= acc_in;
      oper_ff      <= oper_in;
      coef_ff      <= coef_in;
      cnt_ff       <= cnt_in;
      neg_ff       <= neg_in;
      pend_dir_ff  <= pend_dir_in;
      pend_duty_ff <= pend_duty_in;
      pend_cv_ff   <= pend_cv_in;
      pend_done_ff <= pend_done_in;
      pend_emer_ff <= pend_emer_in;
      rsp_data_ff  <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_RESULT))
      else $error("result appeared outside the result state");

   a_cv_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[18:10] != 9'h100)
      else $error("control value outside the clamp range");

   a_done_stopped: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[19]) |->
         (rsp_tdata[18:10] == 9'h000 && rsp_tdata[9:2] == DUTY_STOPPED
          && rsp_tdata[1:0] == DIR_STOP))
      else $error("finished move did not stop the motor");

   a_emer_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[20]) |-> rsp_tdata[19])
      else $error("emergency stop without move end");

   a_idle_after_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && moving_ff && (finish_w || emer_ff)) |=> !moving_ff)
      else $error("move still active after it ended");
`endif

endmodule
